// File: src/lcsg_pkg.sv
// ----------------------------------------------------------------------------
// lcsg_pkg
// shared types, codes and the sine table builder for the chirp generator
// ----------------------------------------------------------------------------
`default_nettype none

package lcsg_pkg;

  localparam int SINE_DEPTH_DEF   = 256;
  localparam int ELAPSED_BITS_DEF = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_RATE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_RATE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DURATION   = 2'd2;

  localparam logic FUNC_UPDATE  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [3:0] MUL_LAST_STEP = 4'd9;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_IDX,
    BK_RD,
    BK_WGT,
    BK_FIN
  } bk_state_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_B0,
    ACC_B32,
    ACC_P0,
    ACC_P16,
    ACC_P32,
    ACC_P48
  } acc_sel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lcsg_qstat_t;

  // table entry for turn fraction u (u below 2^32)
  function automatic logic signed [15:0] sine_entry(input logic [63:0] u);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] acc;
    logic [15:0] mag;
    quad = u[31:30];
    r    = {34'd0, u[29:0]};
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    acc = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (acc > 64'd32767) begin
      acc = 64'd32767;
    end
    mag = acc[15:0];
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

// File: src/lcsg_front.sv
// ----------------------------------------------------------------------------
// lcsg_front
// accepts items, keeps the sweep state and forwards elapsed time per update
// ----------------------------------------------------------------------------
`default_nettype none

module lcsg_front #(
  parameter int ELAPSED_BITS = lcsg_pkg::ELAPSED_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_func,
  input  wire logic [63:0]              in_timestamp_us,
  input  wire logic [31:0]              duration_us,
  input  wire lcsg_pkg::lcsg_qstat_t    qstat,
  output logic                          push,
  output logic [ELAPSED_BITS-1:0]       push_t,
  output logic                          push_zero,
  output logic                          push_done
);
  import lcsg_pkg::*;

  logic [63:0] start_r, start_nxt;
  logic        await_r, await_nxt;
  logic        done_r, done_nxt;
  logic        accept;
  logic [63:0] base;
  logic [63:0] elapsed;
  logic        fin;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  assign base    = await_r ? in_timestamp_us : start_r;
  assign elapsed = in_timestamp_us - base;
  assign fin     = (elapsed[63:32] != '0) || (elapsed[31:0] >= duration_us);

  always_comb begin
    start_nxt = start_r;
    await_nxt = await_r;
    done_nxt  = done_r;
    push      = 1'b0;
    push_t    = '0;
    push_zero = 1'b0;
    push_done = 1'b0;
    if (accept) begin
      if (in_func == FUNC_RESTART) begin
        start_nxt = '0;
        await_nxt = 1'b1;
        done_nxt  = 1'b0;
      end else if (done_r) begin
        push      = 1'b1;
        push_zero = 1'b1;
        push_done = 1'b1;
      end else begin
        push      = 1'b1;
        start_nxt = base;
        await_nxt = 1'b0;
        done_nxt  = fin;
        push_done = fin;
        // saturate elapsed time for the phase
        push_t    = (elapsed[63:ELAPSED_BITS] != '0) ? '1 : elapsed[ELAPSED_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      await_r <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      start_r <= start_nxt;
      await_r <= await_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/lcsg_queue.sv
// ----------------------------------------------------------------------------
// lcsg_queue
// short queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lcsg_queue #(
  parameter int WIDTH = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  push_data,
  input  wire logic              pop,
  output logic [WIDTH-1:0]       pop_data,
  output lcsg_pkg::lcsg_qstat_t  qstat
);
  import lcsg_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_data    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/lcsg_back.sv
// ----------------------------------------------------------------------------
// lcsg_back
// phase by a shared 32x32 multiplier, table lookup, interpolation, result reg
// ----------------------------------------------------------------------------
`default_nettype none

module lcsg_back #(
  parameter int SINE_TABLE_DEPTH = lcsg_pkg::SINE_DEPTH_DEF,
  parameter int ELAPSED_BITS     = lcsg_pkg::ELAPSED_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lcsg_pkg::lcsg_qstat_t     qstat,
  output logic                           pop,
  input  wire logic [ELAPSED_BITS+1:0]   pop_data,
  input  wire logic signed [47:0]        start_rate,
  input  wire logic signed [63:0]        half_sweep_rate,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [15:0]             out_sample,
  output logic                           out_done_res
);
  import lcsg_pkg::*;

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int QW = 32 + IW;

  logic signed [15:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] U = (64'(k) << 32) / SINE_TABLE_DEPTH;
    assign rom[k] = sine_entry(U);
  end

  bk_state_t state_r, state_nxt;

  logic [ELAPSED_BITS-1:0] t_r;
  logic                    zero_r;
  logic                    done_r;
  logic [3:0]              step_r;
  logic [63:0]             prod_r;
  acc_sel_t                tag_r;
  acc_sel_t                tag_sel;
  logic [63:0]             bsq_r;
  logic [63:0]             phase_r;
  logic [IW-1:0]           idx_r;
  logic [IW-1:0]           idxn_r;
  logic [15:0]             w_r;
  logic signed [15:0]      a_r;
  logic signed [15:0]      b_r;
  logic signed [33:0]      wprod_r;
  logic                    out_valid_r;
  logic signed [15:0]      out_sample_r;
  logic                    out_done_r;

  logic [63:0]        t64;
  logic [63:0]        x64;
  logic [31:0]        opa;
  logic [31:0]        opb;
  logic [QW-1:0]      q;
  logic [IW-1:0]      qidx;
  logic               slot_free;
  logic               mul_en;
  logic               fin_fire;
  logic signed [33:0] rnd;
  logic signed [17:0] delta;
  logic signed [17:0] ssum;
  logic signed [15:0] sclamp;

  assign t64 = 64'(t_r);
  assign x64 = 64'(start_rate);

  // operand schedule: t*t, then start_rate*t, then half rate*t^2
  always_comb begin
    unique case (step_r)
      4'd0: begin opa = t64[31:0];              opb = t64[31:0];  tag_sel = ACC_B0;  end
      4'd1: begin opa = t64[63:32];             opb = t64[31:0];  tag_sel = ACC_B32; end
      4'd2: begin opa = t64[31:0];              opb = t64[63:32]; tag_sel = ACC_B32; end
      4'd3: begin opa = x64[31:0];              opb = t64[31:0];  tag_sel = ACC_P16; end
      4'd4: begin opa = x64[63:32];             opb = t64[31:0];  tag_sel = ACC_P48; end
      4'd5: begin opa = x64[31:0];              opb = t64[63:32]; tag_sel = ACC_P48; end
      4'd6: begin opa = half_sweep_rate[31:0];  opb = bsq_r[31:0];  tag_sel = ACC_P0;  end
      4'd7: begin opa = half_sweep_rate[63:32]; opb = bsq_r[31:0];  tag_sel = ACC_P32; end
      4'd8: begin opa = half_sweep_rate[31:0];  opb = bsq_r[63:32]; tag_sel = ACC_P32; end
      default: begin opa = '0; opb = '0; tag_sel = ACC_NONE; end
    endcase
  end

  assign q    = QW'(phase_r[63:32]) * QW'(SINE_TABLE_DEPTH);
  assign qidx = q[QW-1:32];

  assign slot_free = !out_valid_r || !out_stall;

  assign rnd   = wprod_r + 34'sd32768;
  assign delta = 18'(rnd >>> 16);
  assign ssum  = 18'(a_r) + delta;
  always_comb begin
    if (ssum > 18'sd32767) begin
      sclamp = 16'sd32767;
    end else if (ssum < -18'sd32767) begin
      sclamp = -16'sd32767;
    end else begin
      sclamp = ssum[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!qstat.empty) state_nxt = BK_MUL;
      BK_MUL:  if (step_r == MUL_LAST_STEP) state_nxt = BK_IDX;
      BK_IDX:  state_nxt = BK_RD;
      BK_RD:   state_nxt = BK_WGT;
      BK_WGT:  state_nxt = BK_FIN;
      BK_FIN:  if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == BK_IDLE) && !qstat.empty;
    mul_en   = (state_r == BK_MUL);
    fin_fire = (state_r == BK_FIN) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      t_r     <= pop_data[ELAPSED_BITS-1:0];
      zero_r  <= pop_data[ELAPSED_BITS];
      done_r  <= pop_data[ELAPSED_BITS+1];
      step_r  <= '0;
      tag_r   <= ACC_NONE;
      bsq_r   <= '0;
      phase_r <= '0;
    end else if (mul_en) begin
      prod_r <= 64'(opa) * 64'(opb);
      tag_r  <= tag_sel;
      step_r <= step_r + 4'd1;
      unique case (tag_r)
        ACC_B0:   bsq_r   <= bsq_r + prod_r;
        ACC_B32:  bsq_r   <= bsq_r + {prod_r[31:0], 32'd0};
        ACC_P0:   phase_r <= phase_r + prod_r;
        ACC_P16:  phase_r <= phase_r + {prod_r[47:0], 16'd0};
        ACC_P32:  phase_r <= phase_r + {prod_r[31:0], 32'd0};
        ACC_P48:  phase_r <= phase_r + {prod_r[15:0], 48'd0};
        default: ;
      endcase
    end
    if (state_r == BK_IDX) begin
      idx_r  <= qidx;
      idxn_r <= (qidx == IW'(SINE_TABLE_DEPTH - 1)) ? '0 : qidx + IW'(1);
      w_r    <= q[31:16];
    end
    if (state_r == BK_RD) begin
      a_r <= rom[idx_r];
      b_r <= rom[idxn_r];
    end
    if (state_r == BK_WGT) begin
      wprod_r <= (34'(b_r) - 34'(a_r)) * 34'($signed({1'b0, w_r}));
    end
    if (fin_fire) begin
      out_sample_r <= zero_r ? '0 : sclamp;
      out_done_r   <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_done_res = out_done_r;

endmodule

`default_nettype wire

// File: src/linear_chirp_sine_generator.sv
// ----------------------------------------------------------------------------
// linear_chirp_sine_generator
// linear chirp sine source driven by microsecond timestamps
// ----------------------------------------------------------------------------
// Each update item (func 0) gives one Q1.15 sample and a done flag; a restart
// item (func 1) gives no result. The front takes an item in any cycle with
// room in its two-entry queue; per update the back takes it from the queue,
// makes passes through its single 32x32 multiplier for the phase, then
// computes the table index, reads the table, interpolates and hands off the
// result; it takes a new update only after the last one is handed off.
// A stalled result holds the back in its hand-off step. The result register
// holds a finished sample while the next one is computed. Registers are to be
// written by the user only while the block is idle; the block itself does not
// enforce it. cfg_ready is always high.
`default_nettype none

module linear_chirp_sine_generator #(
  parameter int SINE_TABLE_DEPTH = lcsg_pkg::SINE_DEPTH_DEF,
  parameter int ELAPSED_BITS     = lcsg_pkg::ELAPSED_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lcsg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [63:0]                       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_func,
  input  wire logic [63:0]                       in_timestamp_us,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [15:0]                     out_sample,
  output logic                                   out_done_res
);
  import lcsg_pkg::*;

  logic signed [47:0] start_rate_r;
  logic signed [63:0] half_rate_r;
  logic [31:0]        duration_r;

  lcsg_qstat_t             qstat;
  logic                    push;
  logic [ELAPSED_BITS-1:0] push_t;
  logic                    push_zero;
  logic                    push_done;
  logic                    pop;
  logic [ELAPSED_BITS+1:0] pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_rate_r <= '0;
      half_rate_r  <= '0;
      duration_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_RATE: start_rate_r <= cfg_wdata[47:0];
        REG_HALF_RATE:  half_rate_r  <= cfg_wdata;
        REG_DURATION:   duration_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  lcsg_front #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_timestamp_us (in_timestamp_us),
    .duration_us     (duration_r),
    .qstat           (qstat),
    .push            (push),
    .push_t          (push_t),
    .push_zero       (push_zero),
    .push_done       (push_done)
  );

  lcsg_queue #(
    .WIDTH (ELAPSED_BITS + 2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_done, push_zero, push_t}),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  lcsg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .ELAPSED_BITS     (ELAPSED_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (qstat),
    .pop             (pop),
    .pop_data        (pop_data),
    .start_rate      (start_rate_r),
    .half_sweep_rate (half_rate_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_done_res    (out_done_res)
  );

endmodule

`default_nettype wire
